// ===== rtl/pyramid_level_bilinear_sampler_defines.svh =====
// Assertion macros shared by the pyramid level sampler RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef PYRAMID_LEVEL_BILINEAR_SAMPLER_DEFINES_SVH
`define PYRAMID_LEVEL_BILINEAR_SAMPLER_DEFINES_SVH

// Same-cycle implication.
`define PLBS_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define PLBS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/plbs_pkg.sv =====
// Shared constants and types for the pyramid level bilinear sampler.
// No dependencies; imported by the image memory and the top level.
package plbs_pkg;

   localparam int MAX_WIDTH  = 64;
   localparam int MAX_HEIGHT = 64;
   localparam int PIXEL_BITS = 16;

   localparam int COL_W   = $clog2(MAX_WIDTH);
   localparam int ROW_W   = $clog2(MAX_HEIGHT);
   localparam int POS_W   = (COL_W > ROW_W) ? COL_W : ROW_W;
   localparam int ADDR_W  = COL_W + ROW_W;
   localparam int DEPTH   = MAX_WIDTH * MAX_HEIGHT;
   localparam int DIM_W   = 7;

   localparam int COORD_W    = 12;
   localparam int LOAD_ADDR_W = 12;
   localparam int VALUE_W    = 16;
   localparam int OUT_W      = 16;

   localparam int SHIFT_W  = 3;
   localparam int FRAC_W   = 7;
   localparam int WEIGHT_W = FRAC_W + 1;
   localparam int H_W      = PIXEL_BITS + FRAC_W;
   localparam int SUM_W    = PIXEL_BITS + 2 * FRAC_W;
   localparam int PROD_H_W = WEIGHT_W + PIXEL_BITS;
   localparam int PROD_V_W = WEIGHT_W + H_W;

   localparam int PADDR_W = 4;
   localparam int PDATA_W = 32;

   typedef enum logic [1:0] {
      REG_LEVEL_SHIFT  = 2'd0,
      REG_LEVEL_WIDTH  = 2'd1,
      REG_LEVEL_HEIGHT = 2'd2
   } reg_index_type;

   typedef struct packed {
      logic                  we;
      logic [ADDR_W-1:0]     waddr;
      logic [PIXEL_BITS-1:0] wdata;
      logic                  re;
      logic [ADDR_W-1:0]     raddr0;
      logic [ADDR_W-1:0]     raddr1;
   } mem_req_type;

   typedef struct packed {
      logic [POS_W-1:0]  base;
      logic [POS_W-1:0]  next;
      logic [FRAC_W-1:0] frac;
   } axis_type;

endpackage

// ===== rtl/plbs_image_mem.sv =====
// Level image store: one write port and two registered read ports.
// Depends on plbs_pkg for depth, widths and the request struct.
module plbs_image_mem (
   input  logic                            clock,
   input  plbs_pkg::mem_req_type           mem_req,
   output logic [plbs_pkg::PIXEL_BITS-1:0] rd_data0_ff,
   output logic [plbs_pkg::PIXEL_BITS-1:0] rd_data1_ff
);
   import plbs_pkg::*;

   logic [PIXEL_BITS-1:0] image_mem [DEPTH];

   always_ff @(posedge clock) begin
      if (mem_req.we) begin
         image_mem[mem_req.waddr] <= mem_req.wdata;
      end
      if (mem_req.re) begin
         rd_data0_ff <= image_mem[mem_req.raddr0];
         rd_data1_ff <= image_mem[mem_req.raddr1];
      end
   end

endmodule

// ===== rtl/pyramid_level_bilinear_sampler.sv =====
// Pyramid level bilinear sampler: top level, pipeline and register file.
// Depends on plbs_pkg, plbs_image_mem and the assertion macro header.
//
// Usage: requests enter on req_* (valid/stall). req_func 0 stores
// req_load_value at req_load_address and gives no response; req_func 1
// samples at (req_x_coord, req_y_coord) and gives one response on rsp_*.
// Level shift, width and height are set over the APB-style csr port
// (byte addresses 0, 4, 8); the user must write them only while no
// request is in flight, and nothing in the block enforces this. A new
// request waits while a sample's first row is read, since the two read
// ports of the image memory must fetch four neighbors.
// Stages: coordinate map -> two memory reads -> horizontal blend ->
// vertical blend -> output register.
// A stalled response holds the output register and freezes the pipeline;
// req_stall rises until the response is taken.
// Reset clears pipeline valids and restores level 0, 64 x 64. The image
// memory is not cleared and must be loaded before it is sampled.
`include "pyramid_level_bilinear_sampler_defines.svh"

module pyramid_level_bilinear_sampler (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic                             req_func,
   input  logic [plbs_pkg::LOAD_ADDR_W-1:0] req_load_address,
   input  logic [plbs_pkg::VALUE_W-1:0]     req_load_value,
   input  logic [plbs_pkg::COORD_W-1:0]     req_x_coord,
   input  logic [plbs_pkg::COORD_W-1:0]     req_y_coord,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [plbs_pkg::OUT_W-1:0]       rsp_sample_value,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [plbs_pkg::PADDR_W-1:0]     paddr,
   input  logic [plbs_pkg::PDATA_W-1:0]     pwdata,
   output logic [plbs_pkg::PDATA_W-1:0]     prdata,
   output logic                             pready
);
   import plbs_pkg::*;

   function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                  input logic [DIM_W-1:0] maxv);
      logic [DIM_W-1:0] r;
      if (v == '0) begin
         r = DIM_W'(1);
      end else if (v > maxv) begin
         r = maxv;
      end else begin
         r = v;
      end
      return r;
   endfunction

   function automatic axis_type axis_map(input logic [COORD_W-1:0] coord,
                                         input logic [DIM_W-1:0]   dim,
                                         input logic [SHIFT_W-1:0] shift);
      logic [COORD_W-1:0] coarse;
      logic               clip;
      logic [DIM_W-1:0]   pos;
      logic [DIM_W-1:0]   nxt;
      logic [FRAC_W-1:0]  mask;
      axis_type           r;
      coarse = coord >> shift;
      clip   = coarse >= COORD_W'(dim);
      pos    = clip ? dim - DIM_W'(1) : DIM_W'(coarse);
      nxt    = ((pos + DIM_W'(1)) < dim) ? pos + DIM_W'(1) : pos;
      mask   = FRAC_W'((WEIGHT_W'(1) << shift) - WEIGHT_W'(1));
      r.base = POS_W'(pos);
      r.next = POS_W'(nxt);
      r.frac = clip ? '0 : (coord[FRAC_W-1:0] & mask);
      return r;
   endfunction

   // configuration registers
   logic [SHIFT_W-1:0] level_shift_ff, level_shift_in;
   logic [DIM_W-1:0]   level_width_ff, level_width_in;
   logic [DIM_W-1:0]   level_height_ff, level_height_in;
   logic               cfg_write;
   reg_index_type      cfg_sel;

   assign pready    = 1'b1;
   assign cfg_write = psel & penable & pwrite & pready;
   assign cfg_sel   = reg_index_type'(paddr[PADDR_W-1:2]);

   always_comb begin
      level_shift_in  = level_shift_ff;
      level_width_in  = level_width_ff;
      level_height_in = level_height_ff;
      if (cfg_write) begin
         unique case (cfg_sel)
            REG_LEVEL_SHIFT:  level_shift_in  = pwdata[SHIFT_W-1:0];
            REG_LEVEL_WIDTH:  level_width_in  = pwdata[DIM_W-1:0];
            REG_LEVEL_HEIGHT: level_height_in = pwdata[DIM_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (cfg_sel)
         REG_LEVEL_SHIFT:  prdata = PDATA_W'(level_shift_ff);
         REG_LEVEL_WIDTH:  prdata = PDATA_W'(level_width_ff);
         REG_LEVEL_HEIGHT: prdata = PDATA_W'(level_height_ff);
         default:          prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_shift_ff  <= '0;
         level_width_ff  <= DIM_W'(MAX_WIDTH);
         level_height_ff <= DIM_W'(MAX_HEIGHT);
      end else begin
         level_shift_ff  <= level_shift_in;
         level_width_ff  <= level_width_in;
         level_height_ff <= level_height_in;
      end
   end

   // coordinate map at acceptance
   logic [DIM_W-1:0]    width_eff;
   logic [DIM_W-1:0]    height_eff;
   axis_type            axis_x;
   axis_type            axis_y;
   logic [WEIGHT_W-1:0] unit_weight;

   assign width_eff   = clamp_dim(level_width_ff, DIM_W'(MAX_WIDTH));
   assign height_eff  = clamp_dim(level_height_ff, DIM_W'(MAX_HEIGHT));
   assign axis_x      = axis_map(req_x_coord, width_eff, level_shift_ff);
   assign axis_y      = axis_map(req_y_coord, height_eff, level_shift_ff);
   assign unit_weight = WEIGHT_W'(1) << level_shift_ff;

   // pipeline control
   logic advance;
   logic s1_hold;
   logic accept;
   logic s1_valid_ff, s1_valid_in;
   logic s1_sample_ff, s1_sample_in;
   logic s1_phase_ff, s1_phase_in;
   logic m_valid_ff, m_valid_in;
   logic m_bottom_ff;
   logic v_valid_ff, v_valid_in;
   logic rsp_valid_ff, rsp_valid_in;

   assign advance   = !(rsp_valid_ff && rsp_stall);
   assign s1_hold   = s1_valid_ff && s1_sample_ff && !s1_phase_ff;
   assign req_stall = !advance || s1_hold;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      s1_valid_in  = s1_valid_ff;
      s1_sample_in = s1_sample_ff;
      s1_phase_in  = s1_phase_ff;
      m_valid_in   = m_valid_ff;
      v_valid_in   = v_valid_ff;
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         if (s1_hold) begin
            s1_phase_in = 1'b1;
         end else begin
            s1_valid_in  = accept;
            s1_sample_in = req_func;
            s1_phase_in  = 1'b0;
         end
         m_valid_in   = s1_valid_ff && s1_sample_ff;
         v_valid_in   = m_valid_ff && m_bottom_ff;
         rsp_valid_in = v_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s1_sample_ff <= 1'b0;
         s1_phase_ff  <= 1'b0;
         m_valid_ff   <= 1'b0;
         v_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s1_sample_ff <= s1_sample_in;
         s1_phase_ff  <= s1_phase_in;
         m_valid_ff   <= m_valid_in;
         v_valid_ff   <= v_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // request stage payload
   logic [ADDR_W-1:0]     s1_addr_ff;
   logic [PIXEL_BITS-1:0] s1_value_ff;
   axis_type              s1_x_ff;
   axis_type              s1_y_ff;

   always_ff @(posedge clock) begin
      if (advance && !s1_hold && accept) begin
         s1_addr_ff  <= req_load_address[ADDR_W-1:0];
         s1_value_ff <= req_load_value[PIXEL_BITS-1:0];
         s1_x_ff     <= axis_x;
         s1_y_ff     <= axis_y;
      end
   end

   // memory access
   mem_req_type           mem_req;
   logic [POS_W-1:0]      read_row;
   logic [PIXEL_BITS-1:0] rd_data0;
   logic [PIXEL_BITS-1:0] rd_data1;

   assign read_row = s1_phase_ff ? s1_y_ff.next : s1_y_ff.base;

   always_comb begin
      mem_req.we     = advance && s1_valid_ff && !s1_sample_ff;
      mem_req.waddr  = s1_addr_ff;
      mem_req.wdata  = s1_value_ff;
      mem_req.re     = advance && s1_valid_ff && s1_sample_ff;
      mem_req.raddr0 = {ROW_W'(read_row), COL_W'(s1_x_ff.base)};
      mem_req.raddr1 = {ROW_W'(read_row), COL_W'(s1_x_ff.next)};
   end

   plbs_image_mem u_image_mem (
      .clock       (clock),
      .mem_req     (mem_req),
      .rd_data0_ff (rd_data0),
      .rd_data1_ff (rd_data1)
   );

   // read stage payload
   logic [FRAC_W-1:0] m_fx_ff;
   logic [FRAC_W-1:0] m_fy_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         m_bottom_ff <= s1_phase_ff;
         m_fx_ff     <= s1_x_ff.frac;
         m_fy_ff     <= s1_y_ff.frac;
      end
   end

   // horizontal blend
   logic [WEIGHT_W-1:0] weight_x;
   logic [PROD_H_W-1:0] h_prod0;
   logic [PROD_H_W-1:0] h_prod1;
   logic [H_W-1:0]      h_sum;
   logic [H_W-1:0]      top_ff;
   logic [H_W-1:0]      v_top_ff;
   logic [H_W-1:0]      v_bot_ff;
   logic [FRAC_W-1:0]   v_fy_ff;

   assign weight_x = unit_weight - WEIGHT_W'(m_fx_ff);
   assign h_prod0  = PROD_H_W'(weight_x) * PROD_H_W'(rd_data0);
   assign h_prod1  = PROD_H_W'(m_fx_ff) * PROD_H_W'(rd_data1);
   assign h_sum    = H_W'(h_prod0 + h_prod1);

   always_ff @(posedge clock) begin
      if (advance && m_valid_ff && !m_bottom_ff) begin
         top_ff <= h_sum;
      end
      if (advance && m_valid_ff && m_bottom_ff) begin
         v_top_ff <= top_ff;
         v_bot_ff <= h_sum;
         v_fy_ff  <= m_fy_ff;
      end
   end

   // vertical blend and normalize
   logic [WEIGHT_W-1:0] weight_y;
   logic [PROD_V_W-1:0] v_prod0;
   logic [PROD_V_W-1:0] v_prod1;
   logic [SUM_W-1:0]    v_sum;
   logic [SUM_W-1:0]    v_norm;
   logic [OUT_W-1:0]    rsp_value_ff;

   assign weight_y = unit_weight - WEIGHT_W'(v_fy_ff);
   assign v_prod0  = PROD_V_W'(weight_y) * PROD_V_W'(v_top_ff);
   assign v_prod1  = PROD_V_W'(v_fy_ff) * PROD_V_W'(v_bot_ff);
   assign v_sum    = SUM_W'(v_prod0 + v_prod1);
   assign v_norm   = v_sum >> {level_shift_ff, 1'b0};

   always_ff @(posedge clock) begin
      if (advance && v_valid_ff) begin
         rsp_value_ff <= v_norm[OUT_W-1:0];
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_sample_value = rsp_value_ff;

   logic m_top_go;
   logic m_bot_valid;

   assign m_top_go    = m_valid_ff && !m_bottom_ff && advance;
   assign m_bot_valid = m_valid_ff && m_bottom_ff;

   `PLBS_ASSERT_SAME(a_sample_interlock, clock, reset, s1_hold, req_stall, "sample not stalled")
   `PLBS_ASSERT_NEXT(a_row_order, clock, reset, m_top_go, m_bot_valid, "row order broken")
   `PLBS_ASSERT_NEXT(a_blend_to_output, clock, reset, v_valid_ff && advance, rsp_valid_ff, "lost")

endmodule
